// ===== rtl/core/key_repeat_tracker_core_macros.svh =====
// Assertion macros shared by the key repeat tracker checkers.
// No dependencies; included by the checker file.
`ifndef KEY_REPEAT_TRACKER_CORE_MACROS_SVH
`define KEY_REPEAT_TRACKER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define KRT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("krt assertion failed");

// Next-cycle implication, disabled while reset is low.
`define KRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("krt assertion failed");

`endif

// ===== rtl/core/krt_pkg.sv =====
// Types, codes and reset constants for the key repeat tracker.
// No dependencies; used by every RTL file of the block except krt_ram.
package krt_pkg;

  localparam int KEY_W      = 18;
  localparam int TIME_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Command codes
  localparam logic [2:0] CMD_PRESS    = 3'd0;
  localparam logic [2:0] CMD_RELEASE  = 3'd1;
  localparam logic [2:0] CMD_POLL     = 3'd2;
  localparam logic [2:0] CMD_TICK     = 3'd3;
  localparam logic [2:0] CMD_SET_REP  = 3'd4;
  localparam logic [2:0] CMD_ALL_REP  = 3'd5;
  localparam logic [2:0] CMD_DEACT    = 3'd6;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DELAY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MENU_MODE       = 2'd2;

  localparam logic [15:0] RST_INITIAL_DELAY   = 16'd500;
  localparam logic [15:0] RST_REPEAT_INTERVAL = 16'd30;
  localparam logic        RST_MENU_MODE       = 1'b1;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  key_source;
    logic [9:0]  key_code;
    logic [4:0]  key_axis;
    logic        repeat_enable;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic       fired;
    logic [2:0] fire_source;
    logic [9:0] fire_code;
    logic [4:0] fire_axis;
    logic       is_repeat;
    logic       table_full;
    logic       last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOK,
    ST_TAKE,
    ST_TREAD,
    ST_EVAL,
    ST_FULL,
    ST_GLOBAL,
    ST_TICK,
    ST_FLUSH
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;       // capture item, clear scan state
    logic scan;       // step the slot scan
    logic tick;       // scan evaluates repeats instead of matching keys
    logic take;       // allocate the first free slot
    logic time_rd;    // read stamp of the selected slot
    logic key_op;     // apply per-key command, emit result
    logic full_op;    // emit table-full result
    logic global_op;  // apply global command, emit result
    logic flush;      // emit the held tick result (or an empty one) as last
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic hit;
    logic scan_done;
    logic has_free;
  } dp_status_t;

endpackage

// ===== rtl/core/krt_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module krt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/krt_ctrl.sv =====
// Sequencer for the key repeat tracker: decodes the command and steps the datapath.
// Depends on krt_pkg.
module krt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [2:0]          in_cmd,
  input  krt_pkg::dp_status_t status,
  output krt_pkg::ctrl_cmd_t  ctrl,
  output logic                busy
);

  krt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= krt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    case (state_r)
      krt_pkg::ST_IDLE: begin
        if (start) begin
          ctrl.load = 1'b1;
          if (in_cmd inside {krt_pkg::CMD_PRESS, krt_pkg::CMD_RELEASE,
                             krt_pkg::CMD_POLL, krt_pkg::CMD_SET_REP}) begin
            state_nxt = krt_pkg::ST_LOOK;
          end else if (in_cmd == krt_pkg::CMD_TICK) begin
            state_nxt = krt_pkg::ST_TICK;
          end else begin
            state_nxt = krt_pkg::ST_GLOBAL;
          end
        end
      end
      krt_pkg::ST_LOOK: begin
        ctrl.scan = 1'b1;
        if (status.hit) begin
          state_nxt = krt_pkg::ST_TREAD;
        end else if (status.scan_done) begin
          state_nxt = status.has_free ? krt_pkg::ST_TAKE : krt_pkg::ST_FULL;
        end
      end
      krt_pkg::ST_TAKE: begin
        ctrl.take = 1'b1;
        state_nxt = krt_pkg::ST_TREAD;
      end
      krt_pkg::ST_TREAD: begin
        ctrl.time_rd = 1'b1;
        state_nxt    = krt_pkg::ST_EVAL;
      end
      krt_pkg::ST_EVAL: begin
        ctrl.key_op = 1'b1;
        state_nxt   = krt_pkg::ST_IDLE;
      end
      krt_pkg::ST_FULL: begin
        ctrl.full_op = 1'b1;
        state_nxt    = krt_pkg::ST_IDLE;
      end
      krt_pkg::ST_GLOBAL: begin
        ctrl.global_op = 1'b1;
        state_nxt      = krt_pkg::ST_IDLE;
      end
      krt_pkg::ST_TICK: begin
        ctrl.scan = 1'b1;
        ctrl.tick = 1'b1;
        if (status.scan_done) begin
          state_nxt = krt_pkg::ST_FLUSH;
        end
      end
      krt_pkg::ST_FLUSH: begin
        ctrl.flush = 1'b1;
        state_nxt  = krt_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = krt_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != krt_pkg::ST_IDLE);

endmodule

// ===== rtl/core/krt_datapath.sv =====
// Key table, per-slot flags, repeat timing check and result register.
// Depends on krt_pkg and krt_ram.
module krt_datapath #(
  parameter int KEY_SLOTS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  krt_pkg::in_item_t                    in_data,
  input  krt_pkg::ctrl_cmd_t                   ctrl,
  output krt_pkg::dp_status_t                  status,
  input  logic                                 cfg_we,
  input  logic [krt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [krt_pkg::CFG_DATA_W-1:0]       cfg_data,
  output krt_pkg::out_item_t                   out_data,
  output logic                                 out_valid
);

  localparam int IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int CNT_W = $clog2(KEY_SLOTS + 1);

  function automatic krt_pkg::out_item_t mk_result(
    input logic                     fired,
    input logic [krt_pkg::KEY_W-1:0] key,
    input logic                     rep,
    input logic                     full,
    input logic                     last
  );
    krt_pkg::out_item_t r;
    r             = '0;
    r.fired       = fired;
    r.fire_source = fired ? key[17:15] : 3'd0;
    r.fire_code   = fired ? key[14:5]  : 10'd0;
    r.fire_axis   = fired ? key[4:0]   : 5'd0;
    r.is_repeat   = fired & rep;
    r.table_full  = full;
    r.last        = last;
    return r;
  endfunction

  // Registers
  krt_pkg::in_item_t  item_r, item_nxt;
  logic [15:0]        delay_r, delay_nxt;
  logic [15:0]        interval_r, interval_nxt;
  logic               menu_r, menu_nxt;
  logic [KEY_SLOTS-1:0] valid_r, valid_nxt;
  logic [KEY_SLOTS-1:0] active_r, active_nxt;
  logic [KEY_SLOTS-1:0] repeating_r, repeating_nxt;
  logic [KEY_SLOTS-1:0] repeatable_r, repeatable_nxt;
  logic [CNT_W-1:0]   rd_cnt_r, rd_cnt_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0]   slot_r, slot_nxt;
  logic [IDX_W-1:0]   free_idx_r, free_idx_nxt;
  logic               free_found_r, free_found_nxt;
  krt_pkg::out_item_t pend_r, pend_nxt;
  logic               pend_vld_r, pend_vld_nxt;
  krt_pkg::out_item_t out_r, out_nxt;
  logic               out_vld_r, out_vld_nxt;

  // RAM ports
  logic [krt_pkg::KEY_W-1:0]  key_rd;
  logic [krt_pkg::TIME_W-1:0] time_rd;
  logic                       time_we;
  logic [IDX_W-1:0]           time_waddr;
  logic [krt_pkg::TIME_W-1:0] time_wdata;
  logic [IDX_W-1:0]           time_raddr;

  // Repeat check
  logic [krt_pkg::KEY_W-1:0]  item_key;
  logic [IDX_W-1:0]           cur_idx;
  logic [krt_pkg::TIME_W-1:0] elapsed;
  logic [krt_pkg::TIME_W-1:0] thr;
  logic                       eligible;
  logic                       rep_fire;
  logic                       look_cmp;
  logic                       key_match;

  assign item_key  = {item_r.key_source, item_r.key_code, item_r.key_axis};
  assign cur_idx   = ctrl.tick ? cmp_idx_r : slot_r;
  assign elapsed   = item_r.now_ms - time_rd;
  assign thr       = repeating_r[cur_idx] ? {16'd0, interval_r} : {16'd0, delay_r};
  assign eligible  = active_r[cur_idx] & (repeatable_r[cur_idx] | menu_r);
  assign rep_fire  = eligible & (elapsed > thr);
  assign look_cmp  = ctrl.scan & ~ctrl.tick & cmp_vld_r;
  assign key_match = valid_r[cmp_idx_r] & (key_rd == item_key);
  assign time_raddr = ctrl.time_rd ? slot_r : rd_cnt_r[IDX_W-1:0];

  assign status.hit       = look_cmp & key_match;
  assign status.scan_done = cmp_vld_r & (cmp_idx_r == IDX_W'(KEY_SLOTS - 1));
  assign status.has_free  = free_found_r | (cmp_vld_r & ~valid_r[cmp_idx_r]);

  krt_ram #(
    .WIDTH (krt_pkg::KEY_W),
    .DEPTH (KEY_SLOTS)
  ) u_key_ram (
    .clk   (clk),
    .we    (ctrl.take),
    .waddr (free_idx_r),
    .wdata (item_key),
    .raddr (rd_cnt_r[IDX_W-1:0]),
    .rdata (key_rd)
  );

  krt_ram #(
    .WIDTH (krt_pkg::TIME_W),
    .DEPTH (KEY_SLOTS)
  ) u_time_ram (
    .clk   (clk),
    .we    (time_we),
    .waddr (time_waddr),
    .wdata (time_wdata),
    .raddr (time_raddr),
    .rdata (time_rd)
  );

  always_comb begin
    item_nxt       = item_r;
    delay_nxt      = delay_r;
    interval_nxt   = interval_r;
    menu_nxt       = menu_r;
    valid_nxt      = valid_r;
    active_nxt     = active_r;
    repeating_nxt  = repeating_r;
    repeatable_nxt = repeatable_r;
    rd_cnt_nxt     = rd_cnt_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = rd_cnt_r[IDX_W-1:0];
    slot_nxt       = slot_r;
    free_idx_nxt   = free_idx_r;
    free_found_nxt = free_found_r;
    pend_nxt       = pend_r;
    pend_vld_nxt   = pend_vld_r;
    out_nxt        = out_r;
    out_vld_nxt    = 1'b0;
    time_we        = 1'b0;
    time_waddr     = cur_idx;
    time_wdata     = item_r.now_ms;

    if (cfg_we) begin
      case (cfg_index)
        krt_pkg::CFG_INITIAL_DELAY:   delay_nxt    = cfg_data;
        krt_pkg::CFG_REPEAT_INTERVAL: interval_nxt = cfg_data;
        krt_pkg::CFG_MENU_MODE:       menu_nxt     = cfg_data[0];
        default: ;
      endcase
    end

    if (ctrl.load) begin
      item_nxt       = in_data;
      rd_cnt_nxt     = '0;
      free_found_nxt = 1'b0;
      pend_vld_nxt   = 1'b0;
    end

    // Slot scan: issue one read a cycle, compare its data in the following cycle
    if (ctrl.scan && (rd_cnt_r < CNT_W'(KEY_SLOTS))) begin
      rd_cnt_nxt  = rd_cnt_r + 1'b1;
      cmp_vld_nxt = 1'b1;
    end

    if (look_cmp) begin
      if (key_match) begin
        slot_nxt = cmp_idx_r;
      end
      if (!valid_r[cmp_idx_r] && !free_found_r) begin
        free_idx_nxt   = cmp_idx_r;
        free_found_nxt = 1'b1;
      end
    end

    if (ctrl.take) begin
      slot_nxt                   = free_idx_r;
      valid_nxt[free_idx_r]      = 1'b1;
      active_nxt[free_idx_r]     = 1'b0;
      repeating_nxt[free_idx_r]  = 1'b0;
      repeatable_nxt[free_idx_r] = 1'b1;
      time_we                    = 1'b1;
      time_waddr                 = free_idx_r;
      time_wdata                 = '0;
    end

    if (ctrl.key_op) begin
      out_vld_nxt = 1'b1;
      out_nxt     = mk_result(1'b0, '0, 1'b0, 1'b0, 1'b1);
      if (item_r.cmd == krt_pkg::CMD_PRESS && !active_r[slot_r]) begin
        active_nxt[slot_r] = 1'b1;
        time_we            = 1'b1;
        out_nxt            = mk_result(1'b1, item_key, 1'b0, 1'b0, 1'b1);
      end else if (item_r.cmd inside {krt_pkg::CMD_PRESS, krt_pkg::CMD_POLL}) begin
        if (rep_fire) begin
          repeating_nxt[slot_r] = 1'b1;
          time_we               = 1'b1;
          out_nxt               = mk_result(1'b1, item_key, 1'b1, 1'b0, 1'b1);
        end
      end else if (item_r.cmd == krt_pkg::CMD_RELEASE) begin
        active_nxt[slot_r]    = 1'b0;
        repeating_nxt[slot_r] = 1'b0;
      end else begin
        repeatable_nxt[slot_r] = item_r.repeat_enable;
      end
    end

    // Tick: one held result so the final one can carry last
    if (ctrl.tick && cmp_vld_r && valid_r[cmp_idx_r] && rep_fire) begin
      repeating_nxt[cmp_idx_r] = 1'b1;
      time_we                  = 1'b1;
      if (pend_vld_r) begin
        out_nxt     = pend_r;
        out_vld_nxt = 1'b1;
      end
      pend_nxt     = mk_result(1'b1, key_rd, 1'b1, 1'b0, 1'b0);
      pend_vld_nxt = 1'b1;
    end

    if (ctrl.flush) begin
      out_vld_nxt = 1'b1;
      if (pend_vld_r) begin
        out_nxt      = pend_r;
        out_nxt.last = 1'b1;
      end else begin
        out_nxt = mk_result(1'b0, '0, 1'b0, 1'b0, 1'b1);
      end
      pend_vld_nxt = 1'b0;
    end

    if (ctrl.full_op) begin
      out_vld_nxt = 1'b1;
      out_nxt     = mk_result(1'b0, '0, 1'b0, 1'b1, 1'b1);
    end

    if (ctrl.global_op) begin
      out_vld_nxt = 1'b1;
      out_nxt     = mk_result(1'b0, '0, 1'b0, 1'b0, 1'b1);
      case (item_r.cmd)
        krt_pkg::CMD_ALL_REP: repeatable_nxt = '1;
        krt_pkg::CMD_DEACT:   active_nxt     = '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r      <= krt_pkg::RST_INITIAL_DELAY;
      interval_r   <= krt_pkg::RST_REPEAT_INTERVAL;
      menu_r       <= krt_pkg::RST_MENU_MODE;
      valid_r      <= '0;
      active_r     <= '0;
      repeating_r  <= '0;
      repeatable_r <= '1;
      rd_cnt_r     <= '0;
      cmp_vld_r    <= 1'b0;
      free_found_r <= 1'b0;
      pend_vld_r   <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      delay_r      <= delay_nxt;
      interval_r   <= interval_nxt;
      menu_r       <= menu_nxt;
      valid_r      <= valid_nxt;
      active_r     <= active_nxt;
      repeating_r  <= repeating_nxt;
      repeatable_r <= repeatable_nxt;
      rd_cnt_r     <= rd_cnt_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      free_found_r <= free_found_nxt;
      pend_vld_r   <= pend_vld_nxt;
      out_vld_r    <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    slot_r     <= slot_nxt;
    free_idx_r <= free_idx_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
  end

  assign out_data  = out_r;
  assign out_valid = out_vld_r;

endmodule

// ===== rtl/core/key_repeat_tracker_core.sv =====
// Top level of the key repeat tracker: sequencer plus datapath.
// Depends on krt_pkg, krt_ctrl, krt_datapath (and krt_ram below it).
//
//  channel | ports                                  | transaction
//  --------+----------------------------------------+-----------------------------
//  input   | start, busy, in_data                   | start && !busy at clk edge
//  result  | out_valid, out_data                    | out_valid, one cycle, no stall
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid && cfg_ready
//
// Per-key commands: the key search walks the key RAM one slot a cycle; on a miss
//   ST_TAKE allocates a free slot (ST_FULL if none), ST_TREAD reads the slot's
//   stamp and ST_EVAL evaluates. Tick: one slot a cycle through the stamp RAM.
// Global commands run in ST_GLOBAL. Result appears in the same cycle busy drops
//   (tick results may also appear while busy); a new item can be taken then.
// rst_n is synchronous; it resets flags and config, RAM contents are not cleared.
// The result side cannot stall, so there is no backpressure path.
module key_repeat_tracker_core #(
  parameter int KEY_SLOTS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input transactions
  input  logic                            start,
  output logic                            busy,
  input  krt_pkg::in_item_t               in_data,
  // result transactions
  output logic                            out_valid,
  output krt_pkg::out_item_t              out_data,
  // config writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [krt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [krt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  krt_pkg::ctrl_cmd_t  ctrl;
  krt_pkg::dp_status_t status;

  // Config regs live in the datapath and take a write in any cycle.
  assign cfg_ready = 1'b1;

  krt_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_data.cmd),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  krt_datapath #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctrl      (ctrl),
    .status    (status),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data),
    .out_valid (out_valid)
  );

endmodule

// ===== rtl/core/krt_checker.sv =====
// Port-level checks for key_repeat_tracker_core, attached by bind.
// Depends on krt_pkg and key_repeat_tracker_core_macros.svh.
`include "key_repeat_tracker_core_macros.svh"

module krt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input krt_pkg::out_item_t out_data
);

  `KRT_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `KRT_ASSERT_NEXT(a_gap_after_last, clk, rst_n, out_valid && out_data.last, !out_valid)
  // a non-final tick result only shows while the scan or flush is still running
  `KRT_ASSERT_NOW(a_more_results_busy, clk, rst_n, out_valid && !out_data.last, busy)
  `KRT_ASSERT_NOW(a_nofire_zero, clk, rst_n, out_valid && !out_data.fired,
    out_data.fire_source == 3'd0 && out_data.fire_code == 10'd0 &&
    out_data.fire_axis == 5'd0 && !out_data.is_repeat)
  `KRT_ASSERT_NOW(a_full_alone, clk, rst_n, out_valid && out_data.table_full,
    !out_data.fired && out_data.last)

endmodule

bind key_repeat_tracker_core krt_checker u_krt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
